@@ rtl/core/amd_pkg.sv @@
// shared types and constants of the analog to midi deadband block
package amd_pkg;

	localparam int RAW_W   = 10;
	localparam int PITCH_W = 14;
	localparam int CTRL_W  = 7;
	localparam int TICK_W  = 16;
	localparam int CHAN_W  = 4;
	localparam int CFG_W   = 16;

	// output queue holds one full run plus one more message
	localparam int QUEUE_DEPTH = 4;
	localparam int COUNT_W     = $clog2(QUEUE_DEPTH + 1);

	localparam logic [3:0] STATUS_PITCH_BEND = 4'hE;
	localparam logic [3:0] STATUS_CONTROL    = 4'hB;
	localparam logic [6:0] CC_MODULATION     = 7'd1;
	localparam logic [6:0] CC_VOLUME         = 7'd7;

	localparam logic [TICK_W-1:0]  POLL_INTERVAL_RST     = 16'd10;
	localparam logic [PITCH_W-1:0] PITCH_THRESHOLD_RST   = 14'd64;
	localparam logic [CTRL_W-1:0]  CONTROL_THRESHOLD_RST = 7'd1;
	localparam logic [CHAN_W-1:0]  MIDI_CHANNEL_RST      = 4'd0;

	typedef enum logic [1:0] {
		REG_POLL_INTERVAL     = 2'd0,
		REG_PITCH_THRESHOLD   = 2'd1,
		REG_CONTROL_THRESHOLD = 2'd2,
		REG_MIDI_CHANNEL      = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [7:0] status;
		logic [6:0] data1;
		logic [6:0] data2;
	} midi_msg_t;

	typedef struct packed {
		midi_msg_t msg;
		logic      last;
	} queue_entry_t;

	// one decided tick: message per lane and whether that lane sends
	typedef struct packed {
		logic [2:0]            en;
		midi_msg_t [2:0]       msg;
	} msg_group_t;

endpackage

@@ rtl/core/analog_to_midi_deadband.sv @@
// top level of the analog to midi controller with per-channel deadband
//
// Each input request is one millisecond tick with three 10-bit adc readings. A tick is
// accepted every cycle as long as the pipeline moves; ticks that do not poll leave no
// trace beyond the tick counter. A polling tick passes a register stage, a scaling
// stage and a decision stage in which three lanes (pitch, modulation, volume) compare
// against their last sent values in parallel. The merged messages go through a
// four-entry queue and leave one per cycle while out_ready is high; a polling tick
// sends 0 to 3 messages, and the decision stage stalls until a full run of three fits.
// Configuration writes take effect at the next edge and are meant for idle periods.
module analog_to_midi_deadband (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [1:0]                       cfg_index,
	input  logic [amd_pkg::CFG_W-1:0]        cfg_data,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [amd_pkg::RAW_W-1:0]        pitch_raw,
	input  logic [amd_pkg::RAW_W-1:0]        modulation_raw,
	input  logic [amd_pkg::RAW_W-1:0]        volume_raw,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [7:0]                       status_byte,
	output logic [6:0]                       data_first,
	output logic [6:0]                       data_second,
	output logic                             last_of_run
);

	logic [amd_pkg::TICK_W-1:0]  poll_interval_q;
	logic [amd_pkg::PITCH_W-1:0] pitch_threshold_q;
	logic [amd_pkg::CTRL_W-1:0]  control_threshold_q;
	logic [amd_pkg::CHAN_W-1:0]  midi_channel_q;

	logic [amd_pkg::TICK_W-1:0]  tick_q;
	logic [amd_pkg::TICK_W-1:0]  tick_inc;
	logic                        poll;
	logic                        accept;

	logic                        s1_valid_q;
	logic [amd_pkg::RAW_W-1:0]   pitch_raw_s1;
	logic [amd_pkg::RAW_W-1:0]   modulation_raw_s1;
	logic [amd_pkg::RAW_W-1:0]   volume_raw_s1;
	logic                        s1_move;

	logic                        s2_valid_q;
	logic                        s2_free;
	logic [amd_pkg::PITCH_W-1:0] pitch_s2;
	logic [amd_pkg::CTRL_W-1:0]  modulation_s2;
	logic [amd_pkg::CTRL_W-1:0]  volume_s2;

	logic                        fire;
	logic                        merge_can_take;
	logic                        send_pitch;
	logic                        send_mod;
	logic                        send_vol;
	amd_pkg::msg_group_t         grp;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poll_interval_q     <= amd_pkg::POLL_INTERVAL_RST;
			pitch_threshold_q   <= amd_pkg::PITCH_THRESHOLD_RST;
			control_threshold_q <= amd_pkg::CONTROL_THRESHOLD_RST;
			midi_channel_q      <= amd_pkg::MIDI_CHANNEL_RST;
		end else if (cfg_we) begin
			unique case (amd_pkg::cfg_reg_t'(cfg_index))
				amd_pkg::REG_POLL_INTERVAL: begin
					poll_interval_q <= cfg_data;
				end
				amd_pkg::REG_PITCH_THRESHOLD: begin
					pitch_threshold_q <= cfg_data[amd_pkg::PITCH_W-1:0];
				end
				amd_pkg::REG_CONTROL_THRESHOLD: begin
					control_threshold_q <= cfg_data[amd_pkg::CTRL_W-1:0];
				end
				amd_pkg::REG_MIDI_CHANNEL: begin
					midi_channel_q <= cfg_data[amd_pkg::CHAN_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// tick counter saturates, poll restarts it
	assign accept   = in_valid && in_ready;
	assign tick_inc = (tick_q == '1) ? tick_q : (tick_q + 16'd1);
	assign poll     = (tick_inc >= poll_interval_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q <= '0;
		end else if (accept) begin
			tick_q <= poll ? '0 : tick_inc;
		end
	end

	// pipeline handshake
	assign fire     = s2_valid_q && merge_can_take;
	assign s2_free  = !s2_valid_q || fire;
	assign s1_move  = s1_valid_q && s2_free;
	assign in_ready = !s1_valid_q || s1_move;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			s2_valid_q <= 1'b0;
		end else begin
			if (accept && poll) begin
				s1_valid_q <= 1'b1;
			end else if (s1_move) begin
				s1_valid_q <= 1'b0;
			end
			if (s1_move) begin
				s2_valid_q <= 1'b1;
			end else if (fire) begin
				s2_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && poll) begin
			pitch_raw_s1      <= pitch_raw;
			modulation_raw_s1 <= modulation_raw;
			volume_raw_s1     <= volume_raw;
		end
	end

	amd_scale u_scale (
		.clk            (clk),
		.load           (s1_move),
		.pitch_raw      (pitch_raw_s1),
		.modulation_raw (modulation_raw_s1),
		.volume_raw     (volume_raw_s1),
		.pitch_s2       (pitch_s2),
		.modulation_s2  (modulation_s2),
		.volume_s2      (volume_s2)
	);

	amd_lane u_lane_pitch (
		.clk       (clk),
		.arst_n    (arst_n),
		.commit    (fire),
		.value     (pitch_s2),
		.threshold (pitch_threshold_q),
		.send      (send_pitch)
	);

	amd_lane u_lane_mod (
		.clk       (clk),
		.arst_n    (arst_n),
		.commit    (fire),
		.value     ({7'b0, modulation_s2}),
		.threshold ({7'b0, control_threshold_q}),
		.send      (send_mod)
	);

	amd_lane u_lane_vol (
		.clk       (clk),
		.arst_n    (arst_n),
		.commit    (fire),
		.value     ({7'b0, volume_s2}),
		.threshold ({7'b0, control_threshold_q}),
		.send      (send_vol)
	);

	always_comb begin
		grp.en           = {send_vol, send_mod, send_pitch};
		grp.msg[0].status = {amd_pkg::STATUS_PITCH_BEND, midi_channel_q};
		grp.msg[0].data1  = pitch_s2[6:0];
		grp.msg[0].data2  = pitch_s2[13:7];
		grp.msg[1].status = {amd_pkg::STATUS_CONTROL, midi_channel_q};
		grp.msg[1].data1  = amd_pkg::CC_MODULATION;
		grp.msg[1].data2  = modulation_s2;
		grp.msg[2].status = {amd_pkg::STATUS_CONTROL, midi_channel_q};
		grp.msg[2].data1  = amd_pkg::CC_VOLUME;
		grp.msg[2].data2  = volume_s2;
	end

	amd_merge u_merge (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (fire),
		.grp         (grp),
		.can_take    (merge_can_take),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.status_byte (status_byte),
		.data_first  (data_first),
		.data_second (data_second),
		.last_of_run (last_of_run)
	);

`ifndef SYNTHESIS
	// a stalled decision stage keeps its tick
	assert property (@(posedge clk) disable iff (!arst_n)
		(s2_valid_q && !merge_can_take) |=> s2_valid_q)
		else $error("decision stage lost a tick while stalled");

	// a polling tick restarts the counter
	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && poll) |=> (tick_q == '0))
		else $error("tick counter not restarted after poll");

	// only pitch bend or cc1 / cc7 messages leave
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (status_byte[7:4] != amd_pkg::STATUS_PITCH_BEND)) |->
		((status_byte[7:4] == amd_pkg::STATUS_CONTROL)
		&& ((data_first == amd_pkg::CC_MODULATION) || (data_first == amd_pkg::CC_VOLUME))))
		else $error("malformed controller message");
`endif

endmodule

@@ rtl/core/amd_scale.sv @@
// scaling of the three adc readings, registered as pipeline stage two
module amd_scale (
	input  logic                          clk,
	input  logic                          load,
	input  logic [amd_pkg::RAW_W-1:0]     pitch_raw,
	input  logic [amd_pkg::RAW_W-1:0]     modulation_raw,
	input  logic [amd_pkg::RAW_W-1:0]     volume_raw,
	output logic [amd_pkg::PITCH_W-1:0]   pitch_s2,
	output logic [amd_pkg::CTRL_W-1:0]    modulation_s2,
	output logic [amd_pkg::CTRL_W-1:0]    volume_s2
);

	// raw * 127 / 1023, division by 1024 - 1 done as add of the high part
	function automatic logic [amd_pkg::CTRL_W-1:0] scale_ctrl(input logic [9:0] raw);
		logic [16:0] y;
		logic [16:0] t;
		y = {raw, 7'b0} - {7'b0, raw};
		t = y + {10'b0, y[16:10]} + 17'd1;
		return t[16:10];
	endfunction

	logic [8:0]  p_ofs;
	logic [12:0] p_y;
	logic [12:0] p_t;
	logic [3:0]  p_q;
	logic [amd_pkg::PITCH_W-1:0] pitch_val;

	// upper half: 8192 + ofs * 8191 / 511 = 8192 + 16 * ofs + 15 * ofs / 511
	always_comb begin
		p_ofs = pitch_raw[8:0];
		p_y   = {p_ofs, 4'b0} - {4'b0, p_ofs};
		p_t   = p_y + {9'b0, p_y[12:9]} + 13'd1;
		p_q   = p_t[12:9];
		if (pitch_raw[9]) begin
			pitch_val = 14'd8192 + {1'b0, p_ofs, 4'b0} + {10'b0, p_q};
		end else begin
			pitch_val = {1'b0, pitch_raw[8:0], 4'b0};
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			pitch_s2      <= pitch_val;
			modulation_s2 <= scale_ctrl(modulation_raw);
			volume_s2     <= scale_ctrl(volume_raw);
		end
	end

endmodule

@@ rtl/core/amd_lane.sv @@
// deadband lane: last sent value and the send decision for one channel
module amd_lane (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        commit,
	input  logic [amd_pkg::PITCH_W-1:0] value,
	input  logic [amd_pkg::PITCH_W-1:0] threshold,
	output logic                        send
);

	logic [amd_pkg::PITCH_W-1:0] sent_q;
	logic                        seen_q;
	logic [amd_pkg::PITCH_W-1:0] diff;

	always_comb begin
		diff = (value > sent_q) ? (value - sent_q) : (sent_q - value);
		send = !seen_q || (diff >= threshold);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sent_q <= '0;
			seen_q <= 1'b0;
		end else if (commit && send) begin
			sent_q <= value;
			seen_q <= 1'b1;
		end
	end

endmodule

@@ rtl/core/amd_merge.sv @@
// merge of lane results into a message queue that feeds the output port
module amd_merge (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  amd_pkg::msg_group_t grp,
	output logic                can_take,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [7:0]          status_byte,
	output logic [6:0]          data_first,
	output logic [6:0]          data_second,
	output logic                last_of_run
);

	amd_pkg::queue_entry_t q_q [amd_pkg::QUEUE_DEPTH];
	amd_pkg::queue_entry_t q_nxt [amd_pkg::QUEUE_DEPTH];
	logic [amd_pkg::COUNT_W-1:0] count_q;
	logic [amd_pkg::COUNT_W-1:0] count_nxt;
	logic [amd_pkg::COUNT_W-1:0] base;
	logic [amd_pkg::COUNT_W-1:0] pos1;
	logic [amd_pkg::COUNT_W-1:0] pos2;
	logic [amd_pkg::COUNT_W-1:0] n_new;
	logic [2:0]                  last;
	logic                        pop;

	assign out_valid   = (count_q != '0);
	assign pop         = out_valid && out_ready;
	assign status_byte = q_q[0].msg.status;
	assign data_first  = q_q[0].msg.data1;
	assign data_second = q_q[0].msg.data2;
	assign last_of_run = q_q[0].last;

	// a full run of three must fit after this cycle's pop
	assign can_take = (count_q <= amd_pkg::COUNT_W'(amd_pkg::QUEUE_DEPTH - 3))
		|| ((count_q == amd_pkg::COUNT_W'(amd_pkg::QUEUE_DEPTH - 2)) && pop);

	always_comb begin
		last[0] = grp.en[0] && !grp.en[1] && !grp.en[2];
		last[1] = grp.en[1] && !grp.en[2];
		last[2] = grp.en[2];
		base    = count_q - amd_pkg::COUNT_W'(pop);
		pos1    = base + amd_pkg::COUNT_W'(grp.en[0]);
		pos2    = pos1 + amd_pkg::COUNT_W'(grp.en[1]);
		n_new   = amd_pkg::COUNT_W'(grp.en[0]) + amd_pkg::COUNT_W'(grp.en[1])
			+ amd_pkg::COUNT_W'(grp.en[2]);
		count_nxt = push ? (base + n_new) : base;

		for (int i = 0; i < amd_pkg::QUEUE_DEPTH; i++) begin
			if (pop && (i < amd_pkg::QUEUE_DEPTH - 1)) begin
				q_nxt[i] = q_q[i+1];
			end else begin
				q_nxt[i] = q_q[i];
			end
			// compacted append in pitch, modulation, volume order
			if (push && grp.en[0] && (amd_pkg::COUNT_W'(i) == base)) begin
				q_nxt[i] = {grp.msg[0], last[0]};
			end
			if (push && grp.en[1] && (amd_pkg::COUNT_W'(i) == pos1)) begin
				q_nxt[i] = {grp.msg[1], last[1]};
			end
			if (push && grp.en[2] && (amd_pkg::COUNT_W'(i) == pos2)) begin
				q_nxt[i] = {grp.msg[2], last[2]};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_nxt;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < amd_pkg::QUEUE_DEPTH; i++) begin
			q_q[i] <= q_nxt[i];
		end
	end

endmodule

@@ tb/tb_top.sv @@
// self-checking testbench of the analog to midi deadband block
`timescale 1ns / 100ps

module tb_top;
	import amd_pkg::*;

	localparam int HALF_PERIOD    = 6;
	localparam int RESET_CYCLES   = 8;
	localparam int DRAIN_CYCLES   = 12;
	localparam int RX_HOLD_CYCLES = 300;
	localparam int MAX_REPORTS    = 40;
	localparam longint CYCLE_LIMIT = 400_000;

	typedef struct packed {
		logic [RAW_W-1:0] pitch;
		logic [RAW_W-1:0] modulation;
		logic [RAW_W-1:0] volume;
	} adc_tick_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_we = 1'b0;
	logic [1:0]        cfg_index = REG_POLL_INTERVAL;
	logic [CFG_W-1:0]  cfg_data = '0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic [RAW_W-1:0]  pitch_raw = '0;
	logic [RAW_W-1:0]  modulation_raw = '0;
	logic [RAW_W-1:0]  volume_raw = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic [7:0]        status_byte;
	logic [6:0]        data_first;
	logic [6:0]        data_second;
	logic              last_of_run;

	analog_to_midi_deadband u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.pitch_raw      (pitch_raw),
		.modulation_raw (modulation_raw),
		.volume_raw     (volume_raw),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.status_byte    (status_byte),
		.data_first     (data_first),
		.data_second    (data_second),
		.last_of_run    (last_of_run)
	);

	always #(HALF_PERIOD) clk = ~clk;

	// ticks waiting to be offered and midi messages still owed by the block
	adc_tick_t    tick_queue[$];
	queue_entry_t midi_expected[$];

	int unsigned tx_idle_pct = 0;
	int unsigned rx_idle_pct = 0;
	int unsigned hold_requests = 0;
	int unsigned holds_served = 0;
	int unsigned hold_left = 0;
	bit          tick_taken = 1'b0;

	int unsigned mismatches = 0;
	int unsigned ticks_accepted = 0;
	int unsigned polls_seen = 0;
	int unsigned msgs_checked = 0;

	// register copy and channel state of the predictor
	logic [TICK_W-1:0]  poll_every;
	logic [PITCH_W-1:0] bend_deadband;
	logic [CTRL_W-1:0]  cc_deadband;
	logic [CHAN_W-1:0]  chan;
	logic [TICK_W-1:0]  ticks_waited;
	logic [PITCH_W-1:0] bend_sent;
	logic [CTRL_W-1:0]  mod_sent;
	logic [CTRL_W-1:0]  vol_sent;
	bit                 bend_known;
	bit                 mod_known;
	bit                 vol_known;

	int walk_p = 512;
	int walk_m = 512;
	int walk_v = 512;

	function automatic logic [PITCH_W-1:0] bend_of(logic [RAW_W-1:0] raw);
		int r;
		r = int'(raw);
		if (r <= 512)
			return PITCH_W'(r * 16);
		return PITCH_W'(8192 + (r - 512) * 8191 / 511);
	endfunction

	function automatic logic [CTRL_W-1:0] cc_of(logic [RAW_W-1:0] raw);
		return CTRL_W'(int'(raw) * 127 / 1023);
	endfunction

	function automatic int gap(int a, int b);
		return (a > b) ? a - b : b - a;
	endfunction

	task automatic predict_tick(adc_tick_t t);
		logic [PITCH_W-1:0] bend;
		logic [CTRL_W-1:0]  mod;
		logic [CTRL_W-1:0]  vol;
		queue_entry_t       run[$];
		queue_entry_t       e;
		if (ticks_waited != 16'hFFFF)
			ticks_waited++;
		if (ticks_waited < poll_every)
			return;
		ticks_waited = '0;
		polls_seen++;
		bend = bend_of(t.pitch);
		mod = cc_of(t.modulation);
		vol = cc_of(t.volume);
		e.last = 1'b0;
		if (!bend_known || gap(bend, bend_sent) >= int'(bend_deadband)) begin
			e.msg.status = {STATUS_PITCH_BEND, chan};
			e.msg.data1 = bend[6:0];
			e.msg.data2 = bend[13:7];
			run.push_back(e);
			bend_sent = bend;
			bend_known = 1'b1;
		end
		if (!mod_known || gap(mod, mod_sent) >= int'(cc_deadband)) begin
			e.msg.status = {STATUS_CONTROL, chan};
			e.msg.data1 = CC_MODULATION;
			e.msg.data2 = mod;
			run.push_back(e);
			mod_sent = mod;
			mod_known = 1'b1;
		end
		if (!vol_known || gap(vol, vol_sent) >= int'(cc_deadband)) begin
			e.msg.status = {STATUS_CONTROL, chan};
			e.msg.data1 = CC_VOLUME;
			e.msg.data2 = vol;
			run.push_back(e);
			vol_sent = vol;
			vol_known = 1'b1;
		end
		if (run.size() > 0)
			run[run.size() - 1].last = 1'b1;
		foreach (run[i])
			midi_expected.push_back(run[i]);
	endtask

	task automatic flag_mismatch(string what, int got, int want);
		if (mismatches < MAX_REPORTS)
			$display("tb_top: mismatch on %s: got 0x%0h, want 0x%0h at %0t", what, got, want,
				$realtime);
		mismatches++;
	endtask

	// driver: a request stays up until taken, then the next one may follow
	always @(negedge clk) begin
		adc_tick_t nxt;
		if (arst_n && (!in_valid || tick_taken)) begin
			if (tick_queue.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
				nxt = tick_queue.pop_front();
				in_valid <= 1'b1;
				pitch_raw <= nxt.pitch;
				modulation_raw <= nxt.modulation;
				volume_raw <= nxt.volume;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver: random stalls, plus a long hold-off when one is requested
	always @(negedge clk) begin
		if (hold_requests != holds_served) begin
			holds_served = hold_requests;
			hold_left = RX_HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	// monitor: predict on each taken tick, check each delivered message
	always @(posedge clk) begin
		queue_entry_t want;
		tick_taken = (in_valid === 1'b1) && (in_ready === 1'b1);
		if (arst_n && out_valid === 1'b1 && out_ready) begin
			if (midi_expected.size() == 0) begin
				flag_mismatch("message with nothing pending", status_byte, 0);
			end else begin
				want = midi_expected.pop_front();
				msgs_checked++;
				if (status_byte !== want.msg.status)
					flag_mismatch("status_byte", status_byte, want.msg.status);
				if (data_first !== want.msg.data1)
					flag_mismatch("data_first", data_first, want.msg.data1);
				if (data_second !== want.msg.data2)
					flag_mismatch("data_second", data_second, want.msg.data2);
				if (last_of_run !== want.last)
					flag_mismatch("last_of_run", last_of_run, want.last);
			end
		end
		if (arst_n && tick_taken) begin
			ticks_accepted++;
			predict_tick({pitch_raw, modulation_raw, volume_raw});
		end
	end

	task automatic write_reg(cfg_reg_t idx, int unsigned value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CFG_W'(value);
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_POLL_INTERVAL:     poll_every = TICK_W'(value);
			REG_PITCH_THRESHOLD:   bend_deadband = PITCH_W'(value);
			REG_CONTROL_THRESHOLD: cc_deadband = CTRL_W'(value);
			REG_MIDI_CHANNEL:      chan = CHAN_W'(value);
			default: ;
		endcase
	endtask

	task automatic set_regs(int unsigned every, int unsigned bend_db, int unsigned cc_db,
			int unsigned ch);
		write_reg(REG_POLL_INTERVAL, every);
		write_reg(REG_PITCH_THRESHOLD, bend_db);
		write_reg(REG_CONTROL_THRESHOLD, cc_db);
		write_reg(REG_MIDI_CHANNEL, ch);
	endtask

	// block idle: nothing queued, nothing offered, nothing owed, pipeline flushed
	task automatic settle();
		while (tick_queue.size() != 0 || in_valid || midi_expected.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic push_tick(int p, int m, int v);
		tick_queue.push_back({RAW_W'(p), RAW_W'(m), RAW_W'(v)});
	endtask

	// mostly small moves around the last reading so the deadband decides
	function automatic logic [RAW_W-1:0] wander(inout int level);
		int roll;
		roll = $urandom_range(99);
		if (roll < 25)
			level = $urandom_range(1023);
		else if (roll < 35)
			level = roll[0] ? 1023 : 0;
		else
			level = level + int'($urandom_range(20)) - 10;
		if (level < 0)
			level = 0;
		if (level > 1023)
			level = 1023;
		return RAW_W'(level);
	endfunction

	task automatic push_walk(int n);
		adc_tick_t t;
		for (int i = 0; i < n; i++) begin
			t.pitch = wander(walk_p);
			t.modulation = wander(walk_m);
			t.volume = wander(walk_v);
			tick_queue.push_back(t);
		end
	endtask

	initial begin
		poll_every = POLL_INTERVAL_RST;
		bend_deadband = PITCH_THRESHOLD_RST;
		cc_deadband = CONTROL_THRESHOLD_RST;
		chan = MIDI_CHANNEL_RST;
		ticks_waited = '0;
		bend_sent = '0;
		mod_sent = '0;
		vol_sent = '0;
		bend_known = 1'b0;
		mod_known = 1'b0;
		vol_known = 1'b0;

		tx_idle_pct = 36;
		rx_idle_pct = 54;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;

		// reset settings: nine quiet ticks, then a first poll sends on every channel
		push_tick(1023, 1023, 1023);
		push_tick(0, 0, 0);
		push_tick(512, 511, 513);
		push_tick(1, 1022, 2);
		push_tick(513, 512, 511);
		push_tick(1022, 1, 1021);
		push_tick(0, 1023, 0);
		push_tick(1023, 0, 1023);
		push_tick(256, 768, 384);
		push_tick(512, 0, 1023);
		settle();

		// poll on every tick; changes just under and exactly at the deadband
		write_reg(REG_POLL_INTERVAL, 0);
		push_tick(513, 8, 1015);
		push_tick(516, 9, 1015);
		push_tick(0, 1023, 0);
		push_tick(4, 1023, 0);
		push_tick(3, 1023, 0);
		push_tick(1023, 0, 1023);
		push_tick(1022, 1, 1022);
		push_tick(511, 512, 511);
		settle();

		set_regs(1, 64, 1, 5);
		push_walk(30);
		settle();

		tx_idle_pct = 54;
		rx_idle_pct = 36;
		set_regs(3, 16383, 127, 15);
		push_walk(25);
		settle();

		// zero deadband sends all three each poll; the long hold-off fills the block
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		set_regs(2, 0, 0, 9);
		push_walk(30);
		hold_requests++;
		settle();

		// slowest poll rate: a short stretch that never reaches a poll
		set_regs(65535, 64, 0, 0);
		push_walk(5);
		settle();

		$display("tb_top: %0d ticks taken, %0d polls, %0d midi messages checked",
			ticks_accepted, polls_seen, msgs_checked);
		$display("tb_top: poll rates 0 to 65535, deadbands at both ends, channels 0 to 15");
		if (mismatches == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

	initial begin
		#(CYCLE_LIMIT * 2 * HALF_PERIOD);
		$display("tb_top: timeout");
		$display("tb_top: errors");
		$finish;
	end

endmodule
